>>> design/jos_pkg.sv
// ----------------------------------------------------------------------------
// Josephus order unit package
// Field widths, the default ring size and the sequencer state type.
// ----------------------------------------------------------------------------
package jos_pkg;

    localparam int CNT_W         = 7;   // count, target, entry, found_step
    localparam int STEP_W        = 8;   // counting step
    localparam int MAX_COUNT_DEF = 64;  // default ring size

    localparam logic OP_ORDER  = 1'b0;  // emit the removal order
    localparam logic OP_SEARCH = 1'b1;  // search the step for a target

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_REMOVE,
        S_ADVANCE,
        S_EMIT
    } t_state;

endpackage

>>> design/jos_in_if.sv
// ----------------------------------------------------------------------------
// Josephus request channel
// Valid/ready channel that carries one request beat.
// ----------------------------------------------------------------------------
interface jos_in_if
    import jos_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [CNT_W-1:0]  count;
    logic [STEP_W-1:0] step;
    logic [CNT_W-1:0]  target;

    modport source (output valid, opcode, count, step, target, input ready);
    modport sink   (input valid, opcode, count, step, target, output ready);
endinterface

>>> design/jos_out_if.sv
// ----------------------------------------------------------------------------
// Josephus response channel
// Valid/ready channel that carries one result beat.
// ----------------------------------------------------------------------------
interface jos_out_if
    import jos_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] entry;
    logic [CNT_W-1:0] found_step;
    logic             error;
    logic             last;

    modport source (output valid, entry, found_step, error, last, input ready);
    modport sink   (input valid, entry, found_step, error, last, output ready);
endinterface

>>> design/jos_ram.sv
// ----------------------------------------------------------------------------
// Josephus generic RAM
// One write port and one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module jos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> design/josephus_order_and_step_search_unit.sv
// Opcode 0: builds the ring, then removes the entries in order, hopping between removals
//   after the first, and emits one beat per removal, waiting for the sink to be ready.
// Opcode 1: for each trial step t, rebuilds the ring and removes every entry, then emits
//   one result beat on a hit or after the last trial. Error requests give one error beat.
// Throughput: one request at a time; the link RAM's single read port sets the pace.
// Reset: synchronous active-low, returns the sequencer to idle; RAM is not cleared.
// ----------------------------------------------------------------------------
// Josephus order and step search unit
// Builds a linked ring in a RAM, walks it with one shared hop/remove datapath,
// and either streams the removal order or searches the smallest step.
// ----------------------------------------------------------------------------
module josephus_order_and_step_search_unit
    import jos_pkg::*;
#(
    parameter int MAX_COUNT = MAX_COUNT_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    jos_in_if.sink   i_req,
    jos_out_if.source o_rsp
);
    localparam int AW = $clog2(MAX_COUNT);

    // Sequencer state and item fields.
    t_state r_state, n_state;
    logic              r_opcode, n_opcode;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_target, n_target;
    // The counting step; during a search it is the trial step.
    logic [STEP_W-1:0] r_step, n_step;

    // Ring walk state.
    logic [AW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_cursor, n_cursor;
    logic [AW-1:0]     r_trailing, n_trailing;
    logic [CNT_W-1:0]  r_remaining, n_remaining;
    logic [STEP_W-1:0] r_hops, n_hops;

    // Result register.
    logic [CNT_W-1:0]  r_entry, n_entry;
    logic [CNT_W-1:0]  r_found, n_found;
    logic              r_err, n_err;
    logic              r_last, n_last;

    // Link RAM port signals and the same-address bypass.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_wdata;
    logic [AW-1:0]     ram_rdata;
    logic              r_byp;
    logic [AW-1:0]     r_byp_data;
    logic [AW-1:0]     link;

    logic              in_beat;
    logic              out_beat;
    logic              req_bad;
    logic [AW-1:0]     cnt_m1;
    logic              build_end;
    logic [CNT_W-1:0]  removed;
    logic [STEP_W-1:0] hop_reload;
    logic              hit;
    logic              trials_done;

    jos_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_COUNT)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_cursor),
        .o_rdata (ram_rdata)
    );

    // The RAM always reads the link of the cursor that the next cycle will hold,
    // so the successor of the current cursor is ready every cycle. A write to the
    // same slot in the same cycle is forwarded, because the RAM reads first.
    assign link = r_byp ? r_byp_data : ram_rdata;

    assign in_beat  = i_req.valid && i_req.ready;
    assign out_beat = o_rsp.valid && o_rsp.ready;

    // Requests that are answered at once with a single error beat.
    assign req_bad = (i_req.count == '0) || (i_req.count > CNT_W'(MAX_COUNT)) ||
                     ((i_req.opcode == OP_SEARCH) &&
                      ((i_req.target == '0) || (i_req.target > i_req.count)));

    assign cnt_m1      = AW'(r_count - CNT_W'(1));
    assign build_end   = (r_idx == cnt_m1);
    assign removed     = CNT_W'(r_cursor) + CNT_W'(1);
    // A step of zero acts as a step of one: no hops between removals.
    assign hop_reload  = (r_step == '0) ? '0 : r_step - STEP_W'(1);
    assign hit         = (removed == r_target);
    assign trials_done = (r_step == STEP_W'(r_count));

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_state = req_bad ? S_EMIT : S_BUILD;
                end
            end
            S_BUILD: begin
                if (build_end) begin
                    n_state = S_REMOVE;
                end
            end
            S_REMOVE: begin
                if (r_opcode == OP_ORDER) begin
                    n_state = S_EMIT;
                end else if (r_remaining == CNT_W'(1)) begin
                    n_state = (hit || trials_done) ? S_EMIT : S_BUILD;
                end else begin
                    n_state = (hop_reload == '0) ? S_REMOVE : S_ADVANCE;
                end
            end
            S_ADVANCE: begin
                if (r_hops == STEP_W'(1)) begin
                    n_state = S_REMOVE;
                end
            end
            S_EMIT: begin
                if (out_beat) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = (r_hops == '0) ? S_REMOVE : S_ADVANCE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath: ring build, the shared hop/remove step and the result register.
    always_comb begin
        n_opcode    = r_opcode;
        n_count     = r_count;
        n_target    = r_target;
        n_step      = r_step;
        n_idx       = r_idx;
        n_cursor    = r_cursor;
        n_trailing  = r_trailing;
        n_remaining = r_remaining;
        n_hops      = r_hops;
        n_entry     = r_entry;
        n_found     = r_found;
        n_err       = r_err;
        n_last      = r_last;
        ram_we      = 1'b0;
        ram_waddr   = r_trailing;
        ram_wdata   = link;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_opcode = i_req.opcode;
                    n_count  = i_req.count;
                    n_target = i_req.target;
                    n_step   = (i_req.opcode == OP_SEARCH) ? STEP_W'(1) : i_req.step;
                    n_idx    = '0;
                    n_entry  = '0;
                    n_found  = '0;
                    n_err    = 1'b1;
                    n_last   = 1'b1;
                end
            end
            S_BUILD: begin
                // Slot i links to slot i+1; the final slot closes the ring.
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = build_end ? '0 : r_idx + AW'(1);
                n_idx     = r_idx + AW'(1);
                if (build_end) begin
                    n_cursor    = '0;
                    n_trailing  = cnt_m1;
                    n_remaining = r_count;
                end
            end
            S_REMOVE: begin
                // Unlink the cursor slot and move on to its successor.
                ram_we      = 1'b1;
                ram_waddr   = r_trailing;
                ram_wdata   = link;
                n_cursor    = link;
                n_remaining = r_remaining - CNT_W'(1);
                n_hops      = hop_reload;
                if (r_opcode == OP_ORDER) begin
                    n_entry = removed;
                    n_found = '0;
                    n_err   = 1'b0;
                    n_last  = (r_remaining == CNT_W'(1));
                end else if (r_remaining == CNT_W'(1)) begin
                    n_entry = '0;
                    n_last  = 1'b1;
                    if (hit) begin
                        n_found = r_step[CNT_W-1:0];
                        n_err   = 1'b0;
                    end else if (trials_done) begin
                        n_found = '0;
                        n_err   = 1'b1;
                    end else begin
                        n_step = r_step + STEP_W'(1);
                        n_idx  = '0;
                    end
                end
            end
            S_ADVANCE: begin
                n_trailing = r_cursor;
                n_cursor   = link;
                n_hops     = r_hops - STEP_W'(1);
            end
            S_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    // Channel outputs.
    always_comb begin
        i_req.ready      = (r_state == S_IDLE);
        o_rsp.valid      = (r_state == S_EMIT);
        o_rsp.entry      = r_entry;
        o_rsp.found_step = r_found;
        o_rsp.error      = r_err;
        o_rsp.last       = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_opcode    <= OP_ORDER;
            r_step      <= '0;
            r_idx       <= '0;
            r_cursor    <= '0;
            r_trailing  <= '0;
            r_remaining <= '0;
            r_hops      <= '0;
            r_byp       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_opcode    <= n_opcode;
            r_step      <= n_step;
            r_idx       <= n_idx;
            r_cursor    <= n_cursor;
            r_trailing  <= n_trailing;
            r_remaining <= n_remaining;
            r_hops      <= n_hops;
            r_byp       <= ram_we && (ram_waddr == n_cursor);
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_count    <= n_count;
        r_target   <= n_target;
        r_entry    <= n_entry;
        r_found    <= n_found;
        r_err      <= n_err;
        r_last     <= n_last;
        r_byp_data <= ram_wdata;
    end

`ifndef SYNTH
    // A removal always finds at least one entry left in the ring.
    a_remove_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REMOVE) |-> (r_remaining != '0))
        else $error("removal from an empty ring");

    // The ring never holds more entries than the request asked for.
    a_remaining_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REMOVE) |-> (r_remaining <= r_count))
        else $error("ring holds more entries than requested");

    // The final beat of a request returns the unit to idle.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && o_rsp.last) |=> (r_state == S_IDLE))
        else $error("unit busy after the final beat");

    // An error beat carries no entry and no step, and ends the request.
    a_error_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.error) |->
            (o_rsp.entry == '0) && (o_rsp.found_step == '0) && o_rsp.last)
        else $error("malformed error beat");

    // A new request is never taken while a result beat is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_rsp.valid)
        else $error("request accepted while a result is pending");
`endif
endmodule
